>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ACKO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ACKO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/acko_pkg.sv
// Types and constants of the anchored color-key overlay.
package acko_pkg;

	localparam int CFG_ADDR_BITS = 5;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_OVERLAY_WIDTH  = 3'd0,
		REG_OVERLAY_HEIGHT = 3'd1,
		REG_OFFSET_X       = 3'd2,
		REG_OFFSET_Y       = 3'd3,
		REG_ANCHOR_MODE    = 3'd4,
		REG_FRAME_WIDTH    = 3'd5,
		REG_FRAME_HEIGHT   = 3'd6,
		REG_CONTROL        = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ANCHOR_OFF          = 3'd0,
		ANCHOR_TOP_LEFT     = 3'd1,
		ANCHOR_TOP_RIGHT    = 3'd2,
		ANCHOR_BOTTOM_LEFT  = 3'd3,
		ANCHOR_BOTTOM_RIGHT = 3'd4
	} anchor_t;

	typedef enum logic {
		OP_LOAD      = 1'b0,
		OP_COMPOSITE = 1'b1
	} opcode_t;

	typedef logic [31:0] pixel_t;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;

	localparam int CTRL_FLIP_BIT   = 0;
	localparam int CTRL_MODE16_BIT = 1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

>>> src/acko_ram.sv
// Generic single-port RAM with registered read.
module acko_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds when en is low
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> src/anchored_color_key_overlay.sv
// Top level of the anchored color-key overlay.
//
//  channel | handshake                              | payload
//  --------+----------------------------------------+--------------------------------
//  in      | in_valid / in_stall                    | opcode, column, row, pixel_in
//  out     | out_valid / out_stall                  | pixel_out, replaced
//  cfg     | psel, penable, pwrite, pready (APB)    | paddr, pwdata, prdata
//
// One item per clock sustained while the output is not stalled, loads and
// composites alike. A composite item passes three stages (input register,
// address/RAM access, result). The overlay RAM has a single port; it serves
// one load write or one composite read per cycle. Reset clears the pipeline
// valids and loads the register defaults. The overlay store has no reset and
// no clearing pass.
// A stalled output holds its item; the stages behind it keep filling their
// bubbles, and in_stall rises only once all three stages are occupied.
module anchored_color_key_overlay #(
	parameter int MAX_OVERLAY_WIDTH  = 512,
	parameter int MAX_OVERLAY_HEIGHT = 128,
	parameter int COORD_BITS         = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [acko_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [acko_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [acko_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                               pready,
	// input items
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               opcode,
	input  logic [COORD_BITS-1:0]              column,
	input  logic [COORD_BITS-1:0]              row,
	input  acko_pkg::pixel_t                   pixel_in,
	// result items
	output logic                               out_valid,
	input  logic                               out_stall,
	output acko_pkg::pixel_t                   pixel_out,
	output logic                               replaced
);

	import acko_pkg::*;

	// signed working width: frame sizes are 13 bits, plus headroom for
	// the placement sums and a sign
	localparam int SW    = ((COORD_BITS > 13) ? COORD_BITS : 13) + 3;
	localparam int IXB   = $clog2(MAX_OVERLAY_WIDTH);
	localparam int IYB   = $clog2(MAX_OVERLAY_HEIGHT);
	localparam int DEPTH = MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [9:0]  ow_q;
	logic [7:0]  oh_q;
	logic [11:0] ox_q;
	logic [11:0] oy_q;
	anchor_t     anchor_q;
	logic [12:0] fw_q;
	logic [12:0] fh_q;
	logic [1:0]  ctrl_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q     <= '0;
			oh_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			anchor_q <= ANCHOR_OFF;
			fw_q     <= FRAME_WIDTH_RST;
			fh_q     <= FRAME_HEIGHT_RST;
			ctrl_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_OVERLAY_WIDTH:  ow_q     <= pwdata[9:0];
				REG_OVERLAY_HEIGHT: oh_q     <= pwdata[7:0];
				REG_OFFSET_X:       ox_q     <= pwdata[11:0];
				REG_OFFSET_Y:       oy_q     <= pwdata[11:0];
				REG_ANCHOR_MODE:    anchor_q <= anchor_t'(pwdata[2:0]);
				REG_FRAME_WIDTH:    fw_q     <= pwdata[12:0];
				REG_FRAME_HEIGHT:   fh_q     <= pwdata[12:0];
				REG_CONTROL:        ctrl_q   <= pwdata[1:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_OVERLAY_WIDTH:  prdata = CFG_DATA_BITS'(ow_q);
			REG_OVERLAY_HEIGHT: prdata = CFG_DATA_BITS'(oh_q);
			REG_OFFSET_X:       prdata = CFG_DATA_BITS'(ox_q);
			REG_OFFSET_Y:       prdata = CFG_DATA_BITS'(oy_q);
			REG_ANCHOR_MODE:    prdata = CFG_DATA_BITS'(anchor_q);
			REG_FRAME_WIDTH:    prdata = CFG_DATA_BITS'(fw_q);
			REG_FRAME_HEIGHT:   prdata = CFG_DATA_BITS'(fh_q);
			REG_CONTROL:        prdata = CFG_DATA_BITS'(ctrl_q);
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Placement, static between configuration writes
	// ------------------------------------------------------------------
	logic signed [SW-1:0] w_s, h_s, fw_s, fh_s, ox_s, oy_s;
	logic signed [SW-1:0] x0_s, y0_s, xend_s, yend_s;
	logic                 draw_ok;

	always_comb begin
		// overlay sizes saturate at the store dimensions
		w_s  = (32'(ow_q) > 32'(MAX_OVERLAY_WIDTH)) ? SW'(MAX_OVERLAY_WIDTH) : SW'(ow_q);
		h_s  = (32'(oh_q) > 32'(MAX_OVERLAY_HEIGHT)) ? SW'(MAX_OVERLAY_HEIGHT) : SW'(oh_q);
		fw_s = SW'(fw_q);
		fh_s = SW'(fh_q);
		ox_s = SW'(ox_q);
		oy_s = SW'(oy_q);
		case (anchor_q)
			ANCHOR_TOP_LEFT: begin
				x0_s = ox_s;
				y0_s = oy_s;
			end
			ANCHOR_TOP_RIGHT: begin
				x0_s = fw_s - ox_s - w_s;
				y0_s = oy_s;
			end
			ANCHOR_BOTTOM_LEFT: begin
				x0_s = ox_s;
				y0_s = fh_s - oy_s - h_s;
			end
			ANCHOR_BOTTOM_RIGHT: begin
				x0_s = fw_s - ox_s - w_s;
				y0_s = fh_s - oy_s - h_s;
			end
			default: begin
				// off or unknown mode: negative origin, nothing drawn
				x0_s = '1;
				y0_s = '1;
			end
		endcase
		// clip at the right and bottom frame edges
		xend_s  = (x0_s + w_s < fw_s) ? x0_s + w_s : fw_s;
		yend_s  = (y0_s + h_s < fh_s) ? y0_s + h_s : fh_s;
		draw_ok = (x0_s >= 0) && (y0_s >= 0) && (x0_s < fw_s) && (y0_s < fh_s);
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: each stage fills when empty or draining
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic take_s1, take_s2, take_s3, adv_s2;

	opcode_t op_s1, op_s2;

	assign take_s3  = !v_s3 || !out_stall;
	assign adv_s2   = v_s2 && ((op_s2 == OP_LOAD) || take_s3);
	assign take_s2  = !v_s2 || adv_s2;
	assign take_s1  = !v_s1 || take_s2;
	assign in_stall = !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take_s1) begin
				v_s1 <= in_valid;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			// loads end at the RAM write, only composites reach stage 3
			if (take_s3) begin
				v_s3 <= adv_s2 && (op_s2 == OP_COMPOSITE);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register, coverage test, store coordinates
	// ------------------------------------------------------------------
	logic [COORD_BITS-1:0] col_s1, row_s1;
	pixel_t                pix_s1;

	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) begin
			op_s1  <= opcode_t'(opcode);
			col_s1 <= column;
			row_s1 <= row;
			pix_s1 <= pixel_in;
		end
	end

	logic signed [SW-1:0] col_w, row_w, lrow_w, dx_w, dy_w;
	logic                 cover_w, inb_w, hit_w;
	logic [IXB-1:0]       ix_w;
	logic [IYB-1:0]       iy_w;

	always_comb begin
		col_w  = SW'(col_s1);
		row_w  = SW'(row_s1);
		lrow_w = ctrl_q[CTRL_FLIP_BIT] ? fh_s - SW'(1) - row_w : row_w;
		dx_w   = col_w - x0_s;
		dy_w   = lrow_w - y0_s;
		cover_w = draw_ok && (row_w < fh_s) &&
			(col_w >= x0_s) && (col_w < xend_s) &&
			(lrow_w >= y0_s) && (lrow_w < yend_s);
		inb_w = (32'(col_s1) < 32'(MAX_OVERLAY_WIDTH)) &&
			(32'(row_s1) < 32'(MAX_OVERLAY_HEIGHT));
		if (op_s1 == OP_LOAD) begin
			hit_w = inb_w;
			ix_w  = IXB'(col_s1);
			iy_w  = IYB'(row_s1);
		end else begin
			hit_w = cover_w;
			ix_w  = IXB'(dx_w);
			iy_w  = IYB'(dy_w);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: store address, RAM write (load) or read (composite)
	// ------------------------------------------------------------------
	logic           hit_s2;
	logic [IXB-1:0] ix_s2;
	logic [IYB-1:0] iy_s2;
	pixel_t         pix_s2;

	always_ff @(posedge clk) begin
		if (take_s2 && v_s1) begin
			op_s2  <= op_s1;
			hit_s2 <= hit_w;
			ix_s2  <= ix_w;
			iy_s2  <= iy_w;
			pix_s2 <= pix_s1;
		end
	end

	logic [AW-1:0] ram_addr;
	logic          ram_en, ram_we;
	pixel_t        ram_rdata;

	// one port, accesses in item order: a read right after a write of the
	// same entry sees the new data, no forwarding needed
	assign ram_addr = AW'(iy_s2) * AW'(MAX_OVERLAY_WIDTH) + AW'(ix_s2);
	assign ram_en   = adv_s2 && hit_s2;
	assign ram_we   = (op_s2 == OP_LOAD);

	acko_ram #(
		.WIDTH ($bits(pixel_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (pix_s2),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 3: color key and result
	// ------------------------------------------------------------------
	logic   hit_s3;
	pixel_t pix_s3;

	always_ff @(posedge clk) begin
		if (take_s3 && adv_s2) begin
			hit_s3 <= hit_s2;
			pix_s3 <= pix_s2;
		end
	end

	assign out_valid = v_s3;

	// RAM data holds while the result is stalled, so the payload stays put
	always_comb begin
		pixel_out = pix_s3;
		replaced  = 1'b0;
		if (hit_s3) begin
			if (ctrl_q[CTRL_MODE16_BIT]) begin
				if (ram_rdata[15:0] != 16'd0) begin
					pixel_out = {pix_s3[31:16], ram_rdata[15:0]};
					replaced  = 1'b1;
				end
			end else if (ram_rdata != '0) begin
				pixel_out = {ALPHA_OPAQUE, ram_rdata[23:0]};
				replaced  = 1'b1;
			end
		end
	end

endmodule

>>> src/acko_checker.sv
// Port-level checker for the overlay block, bound to the top level.
`include "assert_macros.svh"

module acko_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               psel,
	input logic                               penable,
	input logic                               pwrite,
	input logic                               pready,
	input logic [acko_pkg::CFG_ADDR_BITS-1:0] paddr,
	input logic [acko_pkg::CFG_DATA_BITS-1:0] pwdata,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input acko_pkg::pixel_t                   pixel_out,
	input logic                               replaced
);

	import acko_pkg::*;

	logic     mode16_q;
	reg_idx_t wr_idx;

	assign wr_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

	// shadow of the 16-bit mode bit, taken from register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode16_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (wr_idx == REG_CONTROL)) begin
			mode16_q <= pwdata[CTRL_MODE16_BIT];
		end
	end

	`ACKO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

	`ACKO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pixel_out) && $stable(replaced), "stalled result changed")

	`ACKO_ASSERT_NOW(a_stall_cause, in_valid && in_stall, out_valid && out_stall, "input stalled with output free")

	`ACKO_ASSERT_NOW(a_alpha_forced, out_valid && replaced && !mode16_q, pixel_out[31:24] == ALPHA_OPAQUE, "alpha not forced in 32-bit mode")

endmodule

bind anchored_color_key_overlay acko_checker u_acko_checker (.*);
